// ----- sv/finder_pattern_row_scanner_macros.svh -----
// Assertion macros for the finder pattern row scanner checker.
// Included by the checker file; no other dependencies.
`ifndef FINDER_PATTERN_ROW_SCANNER_MACROS_SVH
`define FINDER_PATTERN_ROW_SCANNER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FPRS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("finder pattern row scanner: assertion failed");

// next-cycle implication, disabled during reset
`define FPRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("finder pattern row scanner: assertion failed");

// next-cycle implication, active during reset
`define FPRS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("finder pattern row scanner: assertion failed");

`endif

// ----- sv/fprs_pkg.sv -----
// Shared types, constants and helpers for the finder pattern row scanner.
// No dependencies.
`default_nettype none

package fprs_pkg;

    localparam int RUN_W     = 12;
    localparam int N_RUNS    = 5;
    localparam int M_TDATA_W = 88;

    typedef logic [RUN_W-1:0]             t_run;
    typedef logic [N_RUNS-1:0][RUN_W-1:0] t_runs;
    typedef logic [2:0]                   t_phase;

    localparam t_run   RUN_MAX = 12'hFFF;

    localparam t_phase PHASE_WHITE_RIGHT = 3'd3;
    localparam t_phase PHASE_LAST        = 3'd4;

    localparam logic CFG_ROW_STEP        = 1'b0;
    localparam logic CFG_BLACK_THRESHOLD = 1'b1;

    localparam logic [3:0] ROW_STEP_RST        = 4'd3;
    localparam logic [7:0] BLACK_THRESHOLD_RST = 8'd128;

    // floor(x/7) = (x * RECIP7) >> RECIP7_SHIFT, exact for x below 43690
    localparam logic [15:0] RECIP7       = 16'd37450;
    localparam int          RECIP7_SHIFT = 18;
    localparam logic [14:0] MIN_TOTAL    = 15'd7;

    function automatic logic absdiff_lt(input logic [13:0] a, input logic [13:0] b,
                                        input logic [13:0] lim);
        logic [13:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d < lim;
    endfunction

endpackage

`default_nettype wire

// ----- sv/finder_pattern_row_scanner.sv -----
// Finder pattern row scanner: thresholds a raster pixel stream and reports
// 1:1:3:1:1 black/white run profiles. Depends on fprs_pkg.
//
// Usage:
//   Slave stream s_axis_*: one grey pixel per transfer, tdata[7:0] = pixel,
//   tuser[0] = row_start, tuser[1] = frame_start.
//   Master stream m_axis_*: one transfer per passing pattern; tdata holds
//   row_index, end_column and the five run lengths, 12 bits each.
//   Config port i_cfg_*: index 0 row_step, index 1 black_threshold; write
//   only while the stream is idle.
// Throughput: one pixel per clock while s_axis_tready is high. The run state
// and the ratio check are evaluated combinationally from the state registers
// and the accepted pixel; the divide by seven is a constant reciprocal multiply.
// Output: a hit is registered into the output register, or into the skid
// buffer while the output is stalled, when the ending white pixel is transferred.
// Stall: an output register plus a one-entry skid buffer; s_axis_tready
// drops only when both are full.
// Reset (synchronous, active low): runs, counters and both output entries
// clear; row_step returns to 3 and black_threshold to 128.
`default_nettype none

module finder_pattern_row_scanner #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // pixel
    input  wire logic [1:0]                     s_axis_tuser,  // row_start, frame_start
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // row_index, end_column, run_outer_black_left, run_white_left,
    // run_center_black, run_white_right, run_outer_black_right, 4 bits zero
    output logic [fprs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

    logic [3:0]             r_row_step;
    logic [7:0]             r_black_threshold;
    fprs_pkg::t_runs        r_runs,  n_runs;
    fprs_pkg::t_phase       r_phase, n_phase;
    logic [CW-1:0]          r_col,   n_col;
    logic [RW-1:0]          r_row,   n_row;
    logic [3:0]             r_rphase, n_rphase;
    logic                   r_active, n_active;

    logic [fprs_pkg::M_TDATA_W-1:0] r_out, r_skid, n_res;
    logic                   r_out_valid, r_skid_valid;

    logic                   accept;
    logic                   out_free;
    logic                   hit;
    logic                   start;
    logic                   black;
    logic [3:0]             step;
    logic [3:0]             stepm1;
    logic [CW-1:0]          col;
    fprs_pkg::t_runs        runs_c;
    fprs_pkg::t_phase       phase_c;
    logic [CW+11:0]         col_ext;
    logic [RW+11:0]         row_ext;

    logic [14:0]            total;
    logic [14:0]            total6;
    logic [30:0]            prod;
    logic [11:0]            m;
    logic [11:0]            v;
    logic [13:0]            m3;
    logic [13:0]            v3;
    logic                   all_nonzero;
    logic                   ratio_ok;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign start = s_axis_tuser[0] || s_axis_tuser[1];
    assign black = s_axis_tdata < r_black_threshold;

    // ratio check on the stored runs; only used when no row start clears them
    assign total = 15'(r_runs[0]) + 15'(r_runs[1]) + 15'(r_runs[2])
                 + 15'(r_runs[3]) + 15'(r_runs[4]);
    assign total6 = total + 15'd6;
    assign prod   = 31'(total6) * 31'(fprs_pkg::RECIP7);
    assign m      = prod[fprs_pkg::RECIP7_SHIFT +: 12];
    assign v      = {1'b0, m[11:1]};
    assign m3     = {1'b0, m, 1'b0} + 14'(m);
    assign v3     = {1'b0, v, 1'b0} + 14'(v);
    assign all_nonzero = (r_runs[0] != '0) && (r_runs[1] != '0) && (r_runs[2] != '0)
                      && (r_runs[3] != '0) && (r_runs[4] != '0);
    assign ratio_ok = all_nonzero && (total >= fprs_pkg::MIN_TOTAL)
        && fprs_pkg::absdiff_lt(14'(m), 14'(r_runs[0]), 14'(v))
        && fprs_pkg::absdiff_lt(14'(m), 14'(r_runs[1]), 14'(v))
        && fprs_pkg::absdiff_lt(m3,     14'(r_runs[2]), v3)
        && fprs_pkg::absdiff_lt(14'(m), 14'(r_runs[3]), 14'(v))
        && fprs_pkg::absdiff_lt(14'(m), 14'(r_runs[4]), 14'(v));

    always_comb begin
        step     = (r_row_step == 4'd0) ? 4'd1 : r_row_step;
        stepm1   = step - 4'd1;
        n_row    = r_row;
        n_rphase = r_rphase;
        n_active = r_active;
        col      = r_col;
        runs_c   = r_runs;
        phase_c  = r_phase;
        if (start) begin
            if (s_axis_tuser[1]) begin
                n_row    = '0;
                n_rphase = 4'd0;
            end else begin
                if (r_row < ROW_LAST) begin
                    n_row = r_row + RW'(1);
                end
                n_rphase = (r_rphase >= stepm1) ? 4'd0 : r_rphase + 4'd1;
            end
            n_active = (n_rphase == stepm1);
            runs_c   = '0;
            phase_c  = '0;
            col      = '0;
        end
        n_col = (col < COL_LAST) ? col + CW'(1) : col;
        if (phase_c > fprs_pkg::PHASE_LAST) begin
            phase_c = fprs_pkg::PHASE_LAST;
        end

        n_runs  = runs_c;
        n_phase = phase_c;
        hit     = 1'b0;
        if (n_active) begin
            if (black || phase_c[0] || (phase_c != fprs_pkg::PHASE_LAST)) begin
                if (phase_c[0] == black) begin
                    n_phase = phase_c + 3'd1;
                end
                if (n_runs[n_phase] != fprs_pkg::RUN_MAX) begin
                    n_runs[n_phase] = n_runs[n_phase] + 12'd1;
                end
            end else if (ratio_ok) begin
                hit     = 1'b1;
                n_runs  = '0;
                n_phase = '0;
            end else begin
                n_runs  = {12'd0, 12'd1, r_runs[4], r_runs[3], r_runs[2]};
                n_phase = fprs_pkg::PHASE_WHITE_RIGHT;
            end
        end
    end

    assign col_ext = {12'd0, col};
    assign row_ext = {12'd0, n_row};
    assign n_res = {4'd0, r_runs[4], r_runs[3], r_runs[2], r_runs[1], r_runs[0],
                    col_ext[11:0], row_ext[11:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_step        <= fprs_pkg::ROW_STEP_RST;
            r_black_threshold <= fprs_pkg::BLACK_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fprs_pkg::CFG_ROW_STEP:        r_row_step        <= i_cfg_data[3:0];
                fprs_pkg::CFG_BLACK_THRESHOLD: r_black_threshold <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runs   <= '0;
            r_phase  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_rphase <= 4'd0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_runs   <= n_runs;
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rphase <= n_rphase;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || (accept && hit);
            r_skid_valid <= 1'b0;
        end else if (accept && hit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (accept && hit) begin
            r_skid <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fprs_checker.sv -----
// Port-level checker for finder_pattern_row_scanner, attached by bind.
// Depends on fprs_pkg and finder_pattern_row_scanner_macros.svh.
`default_nettype none

`include "finder_pattern_row_scanner_macros.svh"

module fprs_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [fprs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic runs_nonzero;
    logic stall;

    assign runs_nonzero = (m_axis_tdata[35:24] != 12'd0) && (m_axis_tdata[47:36] != 12'd0)
                       && (m_axis_tdata[59:48] != 12'd0) && (m_axis_tdata[71:60] != 12'd0)
                       && (m_axis_tdata[83:72] != 12'd0);
    assign stall = m_axis_tvalid && !m_axis_tready;

    `FPRS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)
    `FPRS_ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)
    `FPRS_ASSERT_IMPLIES(a_runs_nonzero, i_clk, i_rst_n, m_axis_tvalid, runs_nonzero)
    `FPRS_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind finder_pattern_row_scanner fprs_checker u_fprs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for finder_pattern_row_scanner: streams pixel rows,
// predicts every finder pattern hit and compares the m_axis results field by field.
// Depends on fprs_pkg and the scanner RTL.

module tb;

    localparam int COL_LAST       = 4095;
    localparam int ROW_LAST       = 4095;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_start;
        logic       frame_start;
    } t_pixel;

    typedef struct packed {
        logic [11:0]      row;
        logic [11:0]      col;
        logic [4:0][11:0] run;
    } t_hit;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;    // pixel
    logic [1:0]  s_axis_tuser  = 2'd0;    // row_start, frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // row_index, end_column, run_outer_black_left, run_white_left,
    // run_center_black, run_white_right, run_outer_black_right, zero pad
    logic [fprs_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = fprs_pkg::CFG_ROW_STEP;
    logic [7:0]  i_cfg_data    = 8'd0;

    finder_pattern_row_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // scanner prediction state
    logic [3:0] cfg_row_step;
    logic [7:0] cfg_thresh;
    int         run_len [5];
    int         run_ph;
    int         col_cnt;
    int         row_cnt;
    int         row_ph;
    bit         row_on;

    t_pixel pixel_q [$];
    t_hit   pending_hits [$];
    t_pixel cur_pixel;

    int  err_count   = 0;
    int  pix_count   = 0;
    int  hit_count   = 0;
    int  gen_count   = 0;
    int  src_gap     = 0;
    int  snk_stall   = 0;
    int  idle_cycles = 0;
    int  gen_thr     = 128;
    int  settings    = 1;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    bit  mark_rs     = 1'b0;
    bit  mark_fs     = 1'b0;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic clear_runs();
        for (int i = 0; i < 5; i++) run_len[i] = 0;
        run_ph = 0;
    endtask

    task automatic extend_run();
        if (run_len[run_ph] < int'(fprs_pkg::RUN_MAX)) run_len[run_ph]++;
    endtask

    task automatic scan_pixel(t_pixel p);
        int   step;
        int   col;
        int   total;
        int   m;
        int   v;
        int   tgt;
        int   lim;
        int   d;
        bit   ok;
        t_hit h;
        step = (cfg_row_step == 0) ? 1 : int'(cfg_row_step);
        if (p.frame_start || p.row_start) begin
            if (p.frame_start) begin
                row_cnt = 0;
                row_ph  = 0;
            end else begin
                if (row_cnt < ROW_LAST) row_cnt++;
                row_ph = (row_ph >= step - 1) ? 0 : row_ph + 1;
            end
            row_on = (row_ph == step - 1);
            clear_runs();
            col = 0;
        end else begin
            col = col_cnt;
        end
        col_cnt = (col < COL_LAST) ? col + 1 : col;
        if (!row_on) return;
        if (p.pixel < cfg_thresh) begin
            if (run_ph % 2 == 1) run_ph++;
            extend_run();
        end else if (run_ph % 2 == 1) begin
            extend_run();
        end else if (run_ph != 4) begin
            run_ph++;
            extend_run();
        end else begin
            ok = 1'b1;
            total = 0;
            for (int i = 0; i < 5; i++) begin
                if (run_len[i] == 0) ok = 1'b0;
                total += run_len[i];
            end
            if (total < 7) ok = 1'b0;
            m = (total + 6) / 7;
            v = m / 2;
            for (int i = 0; i < 5; i++) begin
                tgt = (i == 2) ? 3 * m : m;
                lim = (i == 2) ? 3 * v : v;
                d = (tgt > run_len[i]) ? tgt - run_len[i] : run_len[i] - tgt;
                if (!(d < lim)) ok = 1'b0;
            end
            if (ok) begin
                h.row = 12'(row_cnt);
                h.col = 12'(col);
                for (int i = 0; i < 5; i++) h.run[i] = 12'(run_len[i]);
                pending_hits = {pending_hits, h};
                clear_runs();
            end else begin
                run_len[0] = run_len[2];
                run_len[1] = run_len[3];
                run_len[2] = run_len[4];
                run_len[3] = 1;
                run_len[4] = 0;
                run_ph = 3;
            end
        end
    endtask

    function automatic int draw_idle(bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // pixel source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                scan_pixel(cur_pixel);
                pix_count++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    cur_pixel = pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_pixel.pixel;
                    s_axis_tuser  <= {cur_pixel.frame_start, cur_pixel.row_start};
                    src_gap = draw_idle(src_idle_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result sink
    always @(posedge i_clk) begin : sink
        t_hit h;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_hits.size() == 0) begin
                    report("result transfer with no hit pending");
                end else begin
                    h = pending_hits.pop_front();
                    hit_count++;
                    check_field("row_index", m_axis_tdata[11:0], h.row);
                    check_field("end_column", m_axis_tdata[23:12], h.col);
                    for (int i = 0; i < 5; i++)
                        check_field($sformatf("run%0d", i), m_axis_tdata[24 + 12 * i +: 12],
                                    h.run[i]);
                    check_field("pad", {8'd0, m_axis_tdata[87:84]}, 12'd0);
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                snk_stall = draw_idle(snk_idle_on);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] dark();
        return (gen_thr > 0) ? 8'($urandom_range(0, gen_thr - 1)) : 8'd0;
    endfunction

    function automatic logic [7:0] light();
        return 8'($urandom_range(gen_thr, 255));
    endfunction

    task automatic push_pixel(logic [7:0] v);
        t_pixel p;
        p.pixel       = v;
        p.row_start   = mark_rs;
        p.frame_start = mark_fs;
        pixel_q = {pixel_q, p};
        mark_rs = 1'b0;
        mark_fs = 1'b0;
        gen_count++;
    endtask

    task automatic push_run(bit blk, int len);
        repeat (len) push_pixel(blk ? dark() : light());
    endtask

    task automatic push_pattern(int m, bit exact);
        int len;
        int j;
        j = (m / 2 > 0) ? m / 2 : 1;
        for (int i = 0; i < 5; i++) begin
            len = (i == 2) ? 3 * m : m;
            if (!exact) len += int'($urandom_range(0, 2 * j)) - j;
            if (len < 1) len = 1;
            push_run(i % 2 == 0, len);
        end
        push_pixel(light());
    endtask

    task automatic push_row(bit active);
        int r;
        int m;
        if (!active) begin
            repeat ($urandom_range(1, 3)) push_pixel(8'($urandom()));
            return;
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            repeat ($urandom_range(20, 60)) push_pixel(8'($urandom()));
            return;
        end
        push_run(1'b0, $urandom_range(1, 4));
        repeat ($urandom_range(1, 3)) begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
            // drop the row in the middle of a pattern
            if (r == 1) begin
                push_run(1'b1, m);
                push_run(1'b0, m);
                push_run(1'b1, $urandom_range(1, 3 * m));
                return;
            end
            push_pattern(m, $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5)) push_pixel(8'($urandom()));
            push_run(1'b0, $urandom_range(0, 3));
        end
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_axis_tvalid || pending_hits.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == fprs_pkg::CFG_ROW_STEP) cfg_row_step = val[3:0];
        else cfg_thresh = val;
    endtask

    task automatic scan_setting(int step, int thr, int budget, bit new_frame);
        int row;
        int st;
        wait_idle();
        write_reg(fprs_pkg::CFG_ROW_STEP, 8'(step));
        write_reg(fprs_pkg::CFG_BLACK_THRESHOLD, 8'(thr));
        i_cfg_we <= 1'b0;
        settings++;
        gen_thr     = thr;
        src_idle_on = $urandom_range(0, 3) != 0;
        snk_idle_on = $urandom_range(0, 3) != 0;
        st = (step == 0) ? 1 : step;
        if (new_frame) begin
            mark_fs = 1'b1;
            mark_rs = 1'($urandom_range(0, 1));
            row = 0;
        end else begin
            mark_rs = 1'b1;
            row = st - 1;
        end
        gen_count = 0;
        while (gen_count < budget) begin
            push_row((row % st) == st - 1);
            row++;
            mark_rs = 1'b1;
            if ($urandom_range(0, 39) == 0) begin
                mark_fs = 1'b1;
                mark_rs = 1'($urandom_range(0, 1));
                row = 0;
            end
        end
    endtask

    initial begin
        cfg_row_step = fprs_pkg::ROW_STEP_RST;
        cfg_thresh   = fprs_pkg::BLACK_THRESHOLD_RST;
        clear_runs();
        col_cnt = 0;
        row_cnt = 0;
        row_ph  = 0;
        row_on  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: stray pixels before any row mark, frame mark alone,
        // frame and row mark together, then a module-two pattern on row two
        push_pixel(8'h00);
        push_pixel(8'hFF);
        mark_fs = 1'b1;
        push_pixel(8'h00);
        mark_fs = 1'b1;
        mark_rs = 1'b1;
        push_pixel(8'd127);
        mark_rs = 1'b1;
        push_pixel(8'd128);
        mark_rs = 1'b1;
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'd127);
        push_pixel(8'd128);
        push_pixel(8'hFF);
        repeat (6) push_pixel(8'h00);
        push_pixel(8'd128);
        push_pixel(8'hFF);
        push_pixel(8'd127);
        push_pixel(8'h00);
        push_pixel(8'hFF);

        scan_setting(1, 128, 300, 1'b1);
        scan_setting(15, 255, 200, 1'b0);
        scan_setting(0, 0, 60, 1'b1);
        scan_setting(1, 1, 200, 1'b1);
        scan_setting(2, 200, 300, 1'b0);
        scan_setting(4, 64, 250, 1'b1);
        repeat (2) scan_setting($urandom_range(0, 15), $urandom_range(1, 255), 220,
                                1'($urandom_range(0, 1)));

        wait_idle();
        $display("summary: %0d pixel transfers, %0d finder hits checked, %0d register settings",
                 pix_count, hit_count, settings);
        $display("summary: directed marks, random rows, threshold and row step extremes");
        if (err_count == 0 && pending_hits.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fprs_pkg.sv
sv/finder_pattern_row_scanner.sv
sv/fprs_checker.sv
sim/tb.sv
